// ===== rtl/ptrm_pkg.sv =====
// ----------------------------------------------------------------------------
// ptrm_pkg
// Shared widths, constants and divider request and response types of the
// port transmit rate meter.
// ----------------------------------------------------------------------------
package ptrm_pkg;

	localparam int unsigned PORTS_DEF     = 8;
	localparam int unsigned NUM_RATE_REGS = 8;

	localparam int unsigned PORT_W    = 3;
	localparam int unsigned BYTES_W   = 16;
	localparam int unsigned TIME_W    = 64;
	localparam int unsigned LR_W      = 39;
	localparam int unsigned RATE_W    = 53;
	localparam int unsigned UTIL_W    = 14;
	localparam int unsigned SUM_W     = 20;
	localparam int unsigned CNT_W     = 4;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned THR_W     = 47;

	localparam int unsigned DVD_W  = 54;
	localparam int unsigned DVS_W  = 64;
	localparam int unsigned STEP_W = $clog2(DVD_W);

	localparam logic [CNT_W-1:0]  CLOSE_COUNT  = 4'd10;
	localparam logic [9:0]        WINDOW_SCALE = 10'd1000;
	localparam logic [LR_W-1:0]   RATE_REF     = 39'd100000000000;
	localparam logic [32:0]       BYTE_NS      = 33'd8000000000;
	localparam logic [UTIL_W-1:0] UTIL_FULL    = 14'd10000;
	localparam logic [RATE_W-1:0] RATE_MAX     = '1;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== rtl/ptrm_if.sv =====
// ----------------------------------------------------------------------------
// ptrm_if
// Valid/ready channels carrying packet transactions in and rate results out.
// ----------------------------------------------------------------------------
interface ptrm_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  egress_port;
	logic [15:0] packet_bytes;
	logic [63:0] now_time;

	modport source (output valid, egress_port, packet_bytes, now_time, input ready);
	modport sink (input valid, egress_port, packet_bytes, now_time, output ready);
endinterface

interface ptrm_out_if;
	logic        valid;
	logic        ready;
	logic [52:0] rate_bps;
	logic [13:0] utilization;
	logic [63:0] window_time;
	logic        window_closed;

	modport source (output valid, rate_bps, utilization, window_time, window_closed,
		input ready);
	modport sink (input valid, rate_bps, utilization, window_time, window_closed,
		output ready);
endinterface

// ===== rtl/ptrm_div.sv =====
// ----------------------------------------------------------------------------
// ptrm_div
// Restoring bit-serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ptrm_div
	import ptrm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVD_W-1:0]  quo_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [DVS_W:0]    trial;
	logic [DVS_W+1:0]  diff;
	logic              fits;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, dvs_q};
	assign fits  = !diff[DVS_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== rtl/ptrm_cfg.sv =====
// ----------------------------------------------------------------------------
// ptrm_cfg
// Line rate registers with write decode; a zero rate reads back as one.
// ----------------------------------------------------------------------------
module ptrm_cfg
	import ptrm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [LR_W-1:0]      wr_data,
	input  logic [PORT_W-1:0]    rd_port,
	output logic [LR_W-1:0]      line_rate
);

	logic [LR_W-1:0] rate_q [NUM_RATE_REGS];
	logic [LR_W-1:0] raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_RATE_REGS; i++) begin
				rate_q[i] <= RATE_REF;
			end
		end else if (wr_en) begin
			rate_q[wr_index] <= wr_data;
		end
	end

	assign raw       = rate_q[rd_port];
	assign line_rate = (raw == '0) ? LR_W'(1) : raw;

endmodule

// ===== rtl/port_tx_rate_meter.sv =====
// ----------------------------------------------------------------------------
// port_tx_rate_meter
// Per-port windowed transmit throughput meter with a shared serial divider.
// ----------------------------------------------------------------------------
// A transaction runs on the bit-serial divider, one quotient at a time;
// it needs two to four quotients (serialization time, threshold, rate,
// usage). A transaction for an unknown port is accepted without a result.
// Throughput: one transaction at a time; the input is not ready until the
// result has been taken. Reset clears all port state and sets line rates
// to 100 Gb/s at once.
module port_tx_rate_meter
	import ptrm_pkg::*;
#(
	parameter int unsigned PORTS = PORTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	ptrm_in_if.sink              pkt_in,
	ptrm_out_if.source           res_out,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LR_W-1:0]      cfg_data
);

	localparam int unsigned PIDX_W = (PORTS > 1) ? $clog2(PORTS) : 1;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_SER  = 8'b0000_0010,
		ST_THR  = 8'b0000_0100,
		ST_DEC  = 8'b0000_1000,
		ST_RATE = 8'b0001_0000,
		ST_UTL  = 8'b0010_0000,
		ST_UDIV = 8'b0100_0000,
		ST_OUT  = 8'b1000_0000
	} seq_state_t;

	seq_state_t state_q;

	logic [SUM_W-1:0]  sum_q   [PORTS];
	logic [CNT_W-1:0]  cnt_q   [PORTS];
	logic [TIME_W-1:0] end_q   [PORTS];
	logic [RATE_W-1:0] mrate_q [PORTS];

	logic [PIDX_W-1:0] port_q;
	logic [TIME_W-1:0] now_q;
	logic [LR_W-1:0]   lr_q;
	logic [SUM_W-1:0]  sum_new_q;
	logic [CNT_W-1:0]  cnt_new_q;
	logic [TIME_W-1:0] end_old_q;
	logic [RATE_W-1:0] rate_old_q;
	logic [TIME_W-1:0] cand_q;
	logic [THR_W-1:0]  thresh_q;
	logic [TIME_W-1:0] dt_q;
	logic              closed_q;
	logic [RATE_W-1:0] rate_q;

	logic              div_start_q;
	logic [DVD_W-1:0]  div_dvd_q;
	logic [DVS_W-1:0]  div_dvs_q;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	logic              out_valid_q;
	logic [RATE_W-1:0] out_rate_q;
	logic [UTIL_W-1:0] out_util_q;
	logic [TIME_W-1:0] out_time_q;
	logic              out_closed_q;

	logic [LR_W-1:0]   lr_eff;
	logic [PIDX_W-1:0] pidx;
	logic              accept;
	logic              in_range;
	logic              closed_c;
	logic              rate_full;
	logic              wb;

	ptrm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (cfg_wr_en),
		.wr_index  (cfg_index),
		.wr_data   (cfg_data),
		.rd_port   (pkt_in.egress_port),
		.line_rate (lr_eff)
	);

	assign div_req.start    = div_start_q;
	assign div_req.dividend = div_dvd_q;
	assign div_req.divisor  = div_dvs_q;

	ptrm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign pkt_in.ready = (state_q == ST_IDLE);
	assign accept       = pkt_in.valid && pkt_in.ready;
	assign in_range     = {1'b0, pkt_in.egress_port} < (PORT_W + 1)'(PORTS);
	assign pidx         = pkt_in.egress_port[PIDX_W-1:0];
	assign closed_c     = (cnt_new_q == CLOSE_COUNT) || (dt_q >= TIME_W'(thresh_q));
	assign rate_full    = rate_q >= RATE_W'(lr_q);
	assign wb           = ((state_q == ST_UTL) && rate_full) ||
	                      ((state_q == ST_UDIV) && div_rsp.done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && in_range) begin
						state_q     <= ST_SER;
						div_start_q <= 1'b1;
					end
				end
				ST_SER: begin
					if (div_rsp.done) begin
						state_q     <= ST_THR;
						div_start_q <= 1'b1;
					end
				end
				ST_THR: begin
					if (div_rsp.done) begin
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					if (closed_c && (dt_q != '0)) begin
						state_q     <= ST_RATE;
						div_start_q <= 1'b1;
					end else begin
						state_q <= ST_UTL;
					end
				end
				ST_RATE: begin
					if (div_rsp.done) begin
						state_q <= ST_UTL;
					end
				end
				ST_UTL: begin
					if (rate_full) begin
						state_q     <= ST_OUT;
						out_valid_q <= 1'b1;
					end else begin
						state_q     <= ST_UDIV;
						div_start_q <= 1'b1;
					end
				end
				ST_UDIV: begin
					if (div_rsp.done) begin
						state_q     <= ST_OUT;
						out_valid_q <= 1'b1;
					end
				end
				ST_OUT: begin
					if (res_out.ready) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PORTS; i++) begin
				sum_q[i]   <= '0;
				cnt_q[i]   <= '0;
				end_q[i]   <= '0;
				mrate_q[i] <= '0;
			end
		end else if (wb) begin
			sum_q[port_q]   <= closed_q ? '0 : sum_new_q;
			cnt_q[port_q]   <= closed_q ? '0 : cnt_new_q;
			end_q[port_q]   <= closed_q ? cand_q : end_old_q;
			mrate_q[port_q] <= rate_q;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					port_q     <= pidx;
					now_q      <= pkt_in.now_time;
					lr_q       <= lr_eff;
					sum_new_q  <= sum_q[pidx] + SUM_W'(pkt_in.packet_bytes);
					cnt_new_q  <= cnt_q[pidx] + 1'b1;
					end_old_q  <= end_q[pidx];
					rate_old_q <= mrate_q[pidx];
					div_dvd_q  <= DVD_W'(pkt_in.packet_bytes) * DVD_W'(BYTE_NS);
					div_dvs_q  <= DVS_W'(lr_eff);
				end
			end
			ST_SER: begin
				if (div_rsp.done) begin
					cand_q    <= now_q + TIME_W'(div_rsp.quotient);
					div_dvd_q <= DVD_W'(RATE_REF);
				end
			end
			ST_THR: begin
				if (div_rsp.done) begin
					thresh_q <= THR_W'(div_rsp.quotient) * THR_W'(WINDOW_SCALE);
					dt_q     <= cand_q - end_old_q;
				end
			end
			ST_DEC: begin
				closed_q  <= closed_c;
				rate_q    <= rate_old_q;
				div_dvd_q <= DVD_W'(sum_new_q) * DVD_W'(BYTE_NS);
				div_dvs_q <= dt_q;
			end
			ST_RATE: begin
				if (div_rsp.done) begin
					rate_q <= (|div_rsp.quotient[DVD_W-1:RATE_W]) ? RATE_MAX :
					          div_rsp.quotient[RATE_W-1:0];
				end
			end
			ST_UTL: begin
				div_dvd_q <= DVD_W'(rate_q) * DVD_W'(UTIL_FULL);
				div_dvs_q <= DVS_W'(lr_q);
				if (rate_full) begin
					out_rate_q   <= rate_q;
					out_util_q   <= UTIL_FULL;
					out_time_q   <= closed_q ? cand_q : end_old_q;
					out_closed_q <= closed_q;
				end
			end
			ST_UDIV: begin
				if (div_rsp.done) begin
					out_rate_q   <= rate_q;
					out_util_q   <= (div_rsp.quotient > DVD_W'(UTIL_FULL)) ? UTIL_FULL :
					                div_rsp.quotient[UTIL_W-1:0];
					out_time_q   <= closed_q ? cand_q : end_old_q;
					out_closed_q <= closed_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign res_out.valid         = out_valid_q;
	assign res_out.rate_bps      = out_rate_q;
	assign res_out.utilization   = out_util_q;
	assign res_out.window_time   = out_time_q;
	assign res_out.window_closed = out_closed_q;

endmodule

// ===== rtl/ptrm_chk.sv =====
// ----------------------------------------------------------------------------
// ptrm_chk
// Port-level checks of the rate meter, bound to the top level.
// ----------------------------------------------------------------------------
module ptrm_chk
	import ptrm_pkg::*;
#(
	parameter int unsigned PORTS = PORTS_DEF
) (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [PORT_W-1:0] in_port,
	input logic              out_valid,
	input logic              out_ready,
	input logic [RATE_W-1:0] out_rate,
	input logic [UTIL_W-1:0] out_util
);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("Input ready while a result is pending.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && ({1'b0, in_port} < (PORT_W + 1)'(PORTS))) |=> !in_ready)
		else $error("Input still ready after a transaction for a valid port.");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |=> !out_valid)
		else $error("More than one result for one transaction.");

	a_util_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_util <= UTIL_FULL))
		else $error("Utilization above full scale.");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_rate)))
		else $error("Stalled result changed or dropped.");

endmodule

bind port_tx_rate_meter ptrm_chk #(.PORTS(PORTS)) u_ptrm_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pkt_in.valid),
	.in_ready  (pkt_in.ready),
	.in_port   (pkt_in.egress_port),
	.out_valid (res_out.valid),
	.out_ready (res_out.ready),
	.out_rate  (res_out.rate_bps),
	.out_util  (res_out.utilization)
);
